// ===== design/sqw_pkg.sv =====
// Shared types, constants and codes for the screen quad to world vertex block.
package sqw_pkg;

    localparam int COORD_BITS_DEF   = 21;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int OUT_W   = 21;
    localparam int SCR_W   = 16;
    localparam int CFG_W   = 63;
    localparam int STEP_W  = 16;
    localparam int DEPTH_W = 32;
    localparam int TRIG_W  = 16;
    localparam int SX_W    = 23;
    localparam int VEC_W   = 22;

    localparam logic [31:0] ANG_RECIP  = 32'd1491309;
    localparam int          ANG_SHIFT  = 26;
    localparam logic [31:0] DIV15_MUL  = 32'h8888_8889;
    localparam int          DIV15_SH   = 35;
    localparam int          QOFS_BITS  = 22;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_AXIS  = 2'd1,
        OP_ROT   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        REG_ORIGIN  = 3'd0,
        REG_RIGHT   = 3'd1,
        REG_DOWN    = 3'd2,
        REG_FORWARD = 3'd3,
        REG_STEP    = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ANGLE,
        F_SINE,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROTMUL,
        B_SCREEN,
        B_PLANE,
        B_SUM,
        B_RECIP,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic                      is_rot;
        logic signed [SCR_W-1:0]   x;
        logic signed [SCR_W-1:0]   y;
        logic signed [SCR_W-1:0]   w;
        logic signed [SCR_W-1:0]   h;
        logic signed [TRIG_W-1:0]  sn;
        logic signed [TRIG_W-1:0]  cs;
        logic        [DEPTH_W-1:0] depth;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_qctl;

endpackage

// ===== design/sqw_queue.sv =====
// Two-entry job queue between the front and back parts.
module sqw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sqw_pkg::t_job i_job,
    input  logic          i_pop,
    output sqw_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    sqw_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

// ===== design/sqw_front.sv =====
// Front part: accepts requests, tracks depth, finds sine and cosine for rotated rects.
module sqw_front #(
    parameter int SINE_TABLE_ENTRIES = sqw_pkg::SINE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_op,
    input  logic signed [sqw_pkg::SCR_W-1:0] i_x,
    input  logic signed [sqw_pkg::SCR_W-1:0] i_y,
    input  logic signed [sqw_pkg::SCR_W-1:0] i_w,
    input  logic signed [sqw_pkg::SCR_W-1:0] i_h,
    input  logic signed [sqw_pkg::SCR_W-1:0] i_rot,
    input  logic [sqw_pkg::STEP_W-1:0]    i_step,
    input  logic                          i_full,
    output logic                          o_push,
    output sqw_pkg::t_job                 o_job
);

    localparam int L = $clog2(SINE_TABLE_ENTRIES);

    sqw_pkg::t_fstate r_state, n_state;
    logic signed [sqw_pkg::SCR_W-1:0] r_x, r_y, r_w, r_h;
    logic        r_is_rot;
    logic [20:0] r_m;
    logic [15:0] r_u;
    logic        r_sel;
    logic [1:0]  r_step;
    logic [15:0] r_x2, r_y2;
    logic signed [sqw_pkg::TRIG_W-1:0] r_sn, r_cs;
    logic [sqw_pkg::DEPTH_W-1:0] r_depth;

    logic        acc;
    logic [17:0] a_pos;
    logic [28:0] n_ang;
    logic [41:0] rprod;
    logic [15:0] qang;
    logic [15:0] uu;
    logic [15:0] tt;
    logic [15:0] ma, mb;
    logic [31:0] mprod;
    logic [15:0] mres;
    logic signed [sqw_pkg::TRIG_W-1:0] sres;
    logic [32:0] nd;

    assign o_ready = (r_state == sqw_pkg::F_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        a_pos = 18'($signed(i_rot)) + 18'd46080;
        n_ang = (29'(a_pos) << L) + 29'd11520;
        rprod = 42'(r_m) * 42'(sqw_pkg::ANG_RECIP);
        qang  = rprod[sqw_pkg::ANG_SHIFT +: 16];
        uu    = r_sel ? (r_u + 16'd16384) : r_u;
        tt    = uu[14] ? (16'd16384 - {2'b00, uu[13:0]}) : {2'b00, uu[13:0]};
        case (r_step)
            2'd0:    begin ma = tt;   mb = tt;       end
            2'd1:    begin ma = r_x2; mb = 16'd1160; end
            2'd2:    begin ma = r_x2; mb = r_y2;     end
            default: begin ma = tt;   mb = r_y2;     end
        endcase
        mprod = 32'(ma) * 32'(mb);
        mres  = mprod[29:14];
        sres  = uu[15] ? -$signed(mres) : $signed(mres);
        nd    = 33'(r_depth) + 33'(i_step);
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            sqw_pkg::F_IDLE: begin
                if (acc) begin
                    case (i_op)
                        sqw_pkg::OP_AXIS: n_state = sqw_pkg::F_PUSH;
                        sqw_pkg::OP_ROT:  n_state = sqw_pkg::F_ANGLE;
                        default:          n_state = sqw_pkg::F_IDLE;
                    endcase
                end
            end
            sqw_pkg::F_ANGLE: n_state = sqw_pkg::F_SINE;
            sqw_pkg::F_SINE: begin
                if (r_step == 2'd3 && r_sel) begin
                    n_state = sqw_pkg::F_PUSH;
                end
            end
            sqw_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = sqw_pkg::F_IDLE;
                end
            end
            default: n_state = sqw_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqw_pkg::F_IDLE;
            r_depth <= '0;
            r_sel   <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (acc && i_op == sqw_pkg::OP_BEGIN) begin
                r_depth <= sqw_pkg::DEPTH_W'(i_step);
            end
            if (o_push) begin
                r_depth <= nd[32] ? '1 : nd[31:0];
            end
            if (r_state == sqw_pkg::F_ANGLE) begin
                r_sel  <= 1'b0;
                r_step <= 2'd0;
            end
            if (r_state == sqw_pkg::F_SINE) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_sel <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x      <= i_x;
            r_y      <= i_y;
            r_w      <= i_w;
            r_h      <= i_h;
            r_is_rot <= (i_op == sqw_pkg::OP_ROT);
            r_m      <= 21'(n_ang >> 9);
        end
        if (r_state == sqw_pkg::F_ANGLE) begin
            r_u <= 16'(qang[L-1:0]) << (16 - L);
        end
        if (r_state == sqw_pkg::F_SINE) begin
            case (r_step)
                2'd0:    r_x2 <= mres;
                2'd1:    r_y2 <= 16'd10512 - mres;
                2'd2:    r_y2 <= 16'd25736 - mres;
                default: begin
                    if (r_sel) begin
                        r_cs <= sres;
                    end else begin
                        r_sn <= sres;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_job.is_rot = r_is_rot;
        o_job.x      = r_x;
        o_job.y      = r_y;
        o_job.w      = r_w;
        o_job.h      = r_h;
        o_job.sn     = r_sn;
        o_job.cs     = r_cs;
        o_job.depth  = r_depth;
    end

endmodule

// ===== design/sqw_back.sv =====
// Back part: steps through the four corners and maps each onto the world plane.
module sqw_back #(
    parameter int COORD_BITS = sqw_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sqw_pkg::t_job               i_job,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic [sqw_pkg::CFG_W-1:0]   i_origin,
    input  logic [sqw_pkg::CFG_W-1:0]   i_right,
    input  logic [sqw_pkg::CFG_W-1:0]   i_down,
    input  logic [sqw_pkg::CFG_W-1:0]   i_fwd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_corner,
    output logic [sqw_pkg::OUT_W-1:0]   o_vx,
    output logic [sqw_pkg::OUT_W-1:0]   o_vy,
    output logic [sqw_pkg::OUT_W-1:0]   o_vz,
    output logic                        o_last
);

    localparam int SW = sqw_pkg::SX_W;
    localparam int VW = sqw_pkg::VEC_W;
    localparam logic signed [43:0] BND = 44'sd15 <<< sqw_pkg::QOFS_BITS;
    localparam logic signed [25:0] QOFS = 26'sd1 <<< sqw_pkg::QOFS_BITS;
    localparam logic signed [25:0] VLO = -(26'sd1 <<< (COORD_BITS - 1));
    localparam logic signed [25:0] VHI = (26'sd1 <<< (COORD_BITS - 1)) - 26'sd1;

    sqw_pkg::t_bstate r_state, n_state;
    logic [1:0] r_k;
    logic signed [32:0] r_ctx, r_sty, r_stx, r_cty;
    logic signed [SW-1:0] r_sx, r_sy;
    logic signed [44:0] r_pa [3];
    logic signed [44:0] r_pb [3];
    logic signed [53:0] r_pd [3];
    logic [26:0] r_u [3];
    logic [23:0] r_q [3];
    logic        r_ov;
    logic [1:0]  r_oc;
    logic [sqw_pkg::OUT_W-1:0] r_v [3];
    logic        r_ol;

    logic signed [16:0] tx, ty;
    logic signed [33:0] rx, ry;
    logic signed [22:0] rrx, rry;
    logic signed [SW-1:0] sx, sy;
    logic signed [VW-1:0] co [3];
    logic signed [VW-1:0] dr [3];
    logic signed [VW-1:0] dd [3];
    logic signed [VW-1:0] ff [3];
    logic signed [59:0] msum [3];
    logic signed [43:0] msh [3];
    logic signed [43:0] mcl [3];
    logic [58:0] qp [3];
    logic signed [25:0] vv [3];
    logic signed [25:0] vs [3];
    logic        out_free;

    always_comb begin
        tx = (r_k == 2'd1 || r_k == 2'd2) ? 17'(i_job.w) : -17'(i_job.w);
        ty = (r_k == 2'd2 || r_k == 2'd3) ? 17'(i_job.h) : -17'(i_job.h);
        rx = 34'(r_ctx) - 34'(r_sty);
        ry = 34'(r_stx) + 34'(r_cty);
        rrx = 23'((rx + 34'sd1024) >>> 11);
        rry = 23'((ry + 34'sd1024) >>> 11);
        if (i_job.is_rot) begin
            sx = SW'(rrx) + (SW'(i_job.x) <<< 4);
            sy = SW'(rry) + (SW'(i_job.y) <<< 4);
        end else begin
            sx = (r_k == 2'd1 || r_k == 2'd2) ?
                 ((SW'(i_job.x) + SW'(i_job.w)) <<< 4) : (SW'(i_job.x) <<< 4);
            sy = (r_k == 2'd2 || r_k == 2'd3) ?
                 ((SW'(i_job.y) + SW'(i_job.h)) <<< 4) : (SW'(i_job.y) <<< 4);
        end
        for (int c = 0; c < 3; c++) begin
            co[c] = VW'($signed(i_origin[c*COORD_BITS +: COORD_BITS]));
            dr[c] = VW'($signed(i_right[c*COORD_BITS +: COORD_BITS])) - co[c];
            dd[c] = VW'($signed(i_down[c*COORD_BITS +: COORD_BITS])) - co[c];
            ff[c] = VW'($signed(i_fwd[c*COORD_BITS +: COORD_BITS]));
            msum[c] = 60'(r_pa[c]) * 60'sd6 + 60'(r_pb[c]) * 60'sd8
                    + 60'(r_pd[c]) * 60'sd15 + 60'sd491520;
            msh[c] = 44'(msum[c] >>> 16);
            if (msh[c] > BND) begin
                mcl[c] = BND;
            end else if (msh[c] < -BND) begin
                mcl[c] = -BND;
            end else begin
                mcl[c] = msh[c];
            end
            qp[c] = 59'(r_u[c]) * 59'(sqw_pkg::DIV15_MUL);
            vv[c] = 26'(co[c]) + $signed({2'b00, r_q[c]}) - QOFS;
            if (vv[c] < VLO) begin
                vs[c] = VLO;
            end else if (vv[c] > VHI) begin
                vs[c] = VHI;
            end else begin
                vs[c] = vv[c];
            end
        end
    end

    assign out_free = !r_ov || i_ready;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            sqw_pkg::B_IDLE:   if (!i_empty) n_state = sqw_pkg::B_ROTMUL;
            sqw_pkg::B_ROTMUL: n_state = sqw_pkg::B_SCREEN;
            sqw_pkg::B_SCREEN: n_state = sqw_pkg::B_PLANE;
            sqw_pkg::B_PLANE:  n_state = sqw_pkg::B_SUM;
            sqw_pkg::B_SUM:    n_state = sqw_pkg::B_RECIP;
            sqw_pkg::B_RECIP:  n_state = sqw_pkg::B_OUT;
            sqw_pkg::B_OUT: begin
                if (out_free) begin
                    if (r_k == 2'd3) begin
                        o_pop   = 1'b1;
                        n_state = sqw_pkg::B_IDLE;
                    end else begin
                        n_state = sqw_pkg::B_ROTMUL;
                    end
                end
            end
            default: n_state = sqw_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqw_pkg::B_IDLE;
            r_k     <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sqw_pkg::B_IDLE) begin
                r_k <= 2'd0;
            end
            if (r_state == sqw_pkg::B_OUT && out_free) begin
                r_ov <= 1'b1;
                r_k  <= r_k + 2'd1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sqw_pkg::B_ROTMUL) begin
            r_ctx <= i_job.cs * tx;
            r_sty <= i_job.sn * ty;
            r_stx <= i_job.sn * tx;
            r_cty <= i_job.cs * ty;
        end
        if (r_state == sqw_pkg::B_SCREEN) begin
            r_sx <= sx;
            r_sy <= sy;
        end
        for (int c = 0; c < 3; c++) begin
            if (r_state == sqw_pkg::B_PLANE) begin
                r_pa[c] <= 45'(r_sx) * 45'(dr[c]);
                r_pb[c] <= 45'(r_sy) * 45'(dd[c]);
                r_pd[c] <= $signed({22'd0, i_job.depth}) * 54'(ff[c]);
            end
            if (r_state == sqw_pkg::B_SUM) begin
                r_u[c] <= 27'(mcl[c] + BND);
            end
            if (r_state == sqw_pkg::B_RECIP) begin
                r_q[c] <= qp[c][sqw_pkg::DIV15_SH +: 24];
            end
            if (r_state == sqw_pkg::B_OUT && out_free) begin
                r_v[c] <= sqw_pkg::OUT_W'(vs[c]);
            end
        end
        if (r_state == sqw_pkg::B_OUT && out_free) begin
            r_oc <= r_k;
            r_ol <= (r_k == 2'd3);
        end
    end

    assign o_valid  = r_ov;
    assign o_corner = r_oc;
    assign o_vx     = r_v[0];
    assign o_vy     = r_v[1];
    assign o_vz     = r_v[2];
    assign o_last   = r_ol;

    a_last_is_corner3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_corner == 2'd3)) else $error("last flag off corner 3");
    a_pop_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && o_last)) else $error("pop without final corner");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_corner)))
        else $error("result dropped under stall");

endmodule

// ===== design/screen_quad_to_world_vertices.sv =====
// Top level: configuration registers, front part, job queue and back part.
// Each rect request yields four corner vertices (top-left, top-right, bottom-right,
// bottom-left) with the corner index on tuser and tlast on the fourth. The back part
// picks up a job from idle, then runs six sequenced steps per corner (rotate, screen
// position, plane products, sum, divide, output), the output step waiting out any
// output stall. The front part takes an axis-aligned rect straight to its push step;
// a rotated rect first passes angle and sine steps that compute sine and cosine on
// one shared multiplier. It overlaps with the back part through a two-entry queue.
// Begin requests and unused codes produce no output. Write configuration only while
// no rect is in flight; writes take effect at once and no read-back exists.
module screen_quad_to_world_vertices #(
    parameter int COORD_BITS         = sqw_pkg::COORD_BITS_DEF,
    parameter int SINE_TABLE_ENTRIES = sqw_pkg::SINE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48], rotation_deg[79:64]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // corner_index[1:0]
    output logic [1:0]  m_axis_tuser,
    // vert_x[20:0], vert_y[41:21], vert_z[62:42], zero fill
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [62:0] i_cfg_wdata
);

    logic [sqw_pkg::CFG_W-1:0]  r_origin, r_right, r_down, r_fwd;
    logic [sqw_pkg::STEP_W-1:0] r_step;

    logic          push, pop;
    sqw_pkg::t_job fjob, qjob;
    sqw_pkg::t_qctl qc;
    logic [1:0]    corner;
    logic [sqw_pkg::OUT_W-1:0] vx, vy, vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_right  <= '0;
            r_down   <= '0;
            r_fwd    <= '0;
            r_step   <= sqw_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sqw_pkg::REG_ORIGIN:  r_origin <= i_cfg_wdata;
                sqw_pkg::REG_RIGHT:   r_right  <= i_cfg_wdata;
                sqw_pkg::REG_DOWN:    r_down   <= i_cfg_wdata;
                sqw_pkg::REG_FORWARD: r_fwd    <= i_cfg_wdata;
                sqw_pkg::REG_STEP:    r_step   <= i_cfg_wdata[sqw_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign qc.push = push;
    assign qc.pop  = pop;

    sqw_front #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_x     (s_axis_tdata[15:0]),
        .i_y     (s_axis_tdata[31:16]),
        .i_w     (s_axis_tdata[47:32]),
        .i_h     (s_axis_tdata[63:48]),
        .i_rot   (s_axis_tdata[79:64]),
        .i_step  (r_step),
        .i_full  (qc.full),
        .o_push  (push),
        .o_job   (fjob)
    );

    sqw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (qc.push),
        .i_job   (fjob),
        .i_pop   (qc.pop),
        .o_job   (qjob),
        .o_full  (qc.full),
        .o_empty (qc.empty)
    );

    sqw_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (qjob),
        .i_empty  (qc.empty),
        .o_pop    (pop),
        .i_origin (r_origin),
        .i_right  (r_right),
        .i_down   (r_down),
        .i_fwd    (r_fwd),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_corner (corner),
        .o_vx     (vx),
        .o_vy     (vy),
        .o_vz     (vz),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tuser = corner;
    assign m_axis_tdata = {1'b0, vz, vy, vx};

endmodule

// ===== tb/screen_quad_to_world_vertices_test.sv =====
// Testbench for screen_quad_to_world_vertices: directed table plus random rect requests.
module screen_quad_to_world_vertices_test;

    localparam longint PLANE_DEN = 983040;
    localparam longint TURN_Q6   = 23040;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] x, y, w, h, deg;
    } t_rect_req;

    typedef struct packed {
        logic [1:0]  idx;
        logic [20:0] vx, vy, vz;
        logic        last;
    } t_vertex;

    typedef struct {
        t_rect_req   req;
        logic        has_known;
        logic [20:0] known_vx;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = '0;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [1:0]  m_axis_tuser;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [62:0] i_cfg_wdata = '0;

    logic [62:0] origin_pt, right_pt, down_pt, fwd_dir;
    logic [15:0] step_size;
    logic [31:0] plane_depth;

    t_vertex     vertex_queue[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off_go = 1'b0;
    bit          hold_off_taken = 1'b0;
    int          hold_off_left = 0;
    logic [20:0] known_first_vx[$];

    screen_quad_to_world_vertices dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint sext21(logic [62:0] packed_vec, int k);
        return longint'(signed'(packed_vec[k*21 +: 21]));
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if (n < 0 && (n % d) != 0) q--;
        return q;
    endfunction

    function automatic longint sine_q14(logic [15:0] u);
        longint r, t, x2, y;
        r = longint'(u[13:0]);
        t = u[14] ? 16384 - r : r;
        x2 = (t * t) / 16384;
        y = 10512 - (x2 * 1160) / 16384;
        y = 25736 - (x2 * y) / 16384;
        y = (t * y) / 16384;
        return u[15] ? -y : y;
    endfunction

    function automatic t_vertex world_vertex(longint sx, longint sy, int k);
        t_vertex v;
        longint o, n, r;
        longint comp[3];
        for (int c = 0; c < 3; c++) begin
            o = sext21(origin_pt, c);
            n = o * PLANE_DEN + 6 * sx * (sext21(right_pt, c) - o)
                + 8 * sy * (sext21(down_pt, c) - o)
                + 15 * longint'(plane_depth) * sext21(fwd_dir, c);
            r = floor_div(n + PLANE_DEN / 2, PLANE_DEN);
            if (r < -1048576) r = -1048576;
            if (r > 1048575) r = 1048575;
            comp[c] = r;
        end
        v.idx = k[1:0];
        v.vx = comp[0][20:0];
        v.vy = comp[1][20:0];
        v.vz = comp[2][20:0];
        v.last = (k == 3);
        return v;
    endfunction

    task automatic predict_rect(t_rect_req r);
        longint x, y, w, h, a, p, sn, cs, tx, ty, px, py, nd;
        logic [15:0] u;
        int cx[4] = '{-1, 1, 1, -1};
        int cy[4] = '{-1, -1, 1, 1};
        x = longint'(signed'(r.x));
        y = longint'(signed'(r.y));
        w = longint'(signed'(r.w));
        h = longint'(signed'(r.h));
        if (r.op == sqw_pkg::OP_BEGIN) begin
            plane_depth = {16'd0, step_size};
            return;
        end
        if (r.op == OP_UNUSED) return;
        if (r.op == sqw_pkg::OP_AXIS) begin
            for (int k = 0; k < 4; k++) begin
                px = cx[k] > 0 ? x + w : x;
                py = cy[k] > 0 ? y + h : y;
                vertex_queue.push_back(world_vertex(px * 16, py * 16, k));
            end
        end else begin
            a = longint'(signed'(r.deg)) + 2 * TURN_Q6;
            p = ((a * 1024 + TURN_Q6 / 2) / TURN_Q6) % 1024;
            u = 16'((p * 65536) / 1024);
            sn = sine_q14(u);
            cs = sine_q14(u + 16'd16384);
            for (int k = 0; k < 4; k++) begin
                tx = cx[k] * w;
                ty = cy[k] * h;
                px = floor_div(cs * tx - sn * ty + 1024, 2048) + x * 16;
                py = floor_div(sn * tx + cs * ty + 1024, 2048) + y * 16;
                vertex_queue.push_back(world_vertex(px, py, k));
            end
        end
        nd = longint'(plane_depth) + longint'(step_size);
        plane_depth = nd > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : nd[31:0];
    endtask

    task automatic write_reg(sqw_pkg::t_reg idx, logic [62:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sqw_pkg::REG_ORIGIN:  origin_pt = value;
            sqw_pkg::REG_RIGHT:   right_pt = value;
            sqw_pkg::REG_DOWN:    down_pt = value;
            sqw_pkg::REG_FORWARD: fwd_dir = value;
            default:              step_size = value[15:0];
        endcase
    endtask

    task automatic drain_queue();
        s_axis_tvalid <= 1'b0;
        while (vertex_queue.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Leaves tvalid high after acceptance; the next idle cycle or drain drops it.
    task automatic send_rect(t_rect_req r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser <= r.op;
        s_axis_tdata <= {r.deg, r.h, r.w, r.y, r.x};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_rect(r);
        @(negedge i_clk);
    endtask

    function automatic t_rect_req random_rect();
        t_rect_req r;
        int pick;
        pick = $urandom_range(99);
        r.op = pick < 6 ? sqw_pkg::OP_BEGIN :
               (pick < 8 ? OP_UNUSED : (pick < 54 ? sqw_pkg::OP_AXIS : sqw_pkg::OP_ROT));
        r.x = $urandom;
        r.y = $urandom;
        r.w = $urandom;
        r.h = $urandom;
        r.deg = 16'($urandom_range(46079) - 23040);
        if ($urandom_range(3) != 0) begin
            r.x = 16'($urandom_range(10240));
            r.y = 16'($urandom_range(7680));
            r.w = 16'($urandom_range(4096));
            r.h = 16'($urandom_range(4096));
        end
        return r;
    endfunction

    function automatic logic [62:0] random_vec(bit wide);
        logic [62:0] v;
        v = {$urandom, $urandom};
        if (!wide) begin
            for (int c = 0; c < 3; c++)
                v[c*21 +: 21] = 21'($urandom_range(16384) - 8192);
        end
        return v;
    endfunction

    // Receiver: random stall and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_off_go && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_off_left = 400;
        end
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_vertex want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.idx = m_axis_tuser;
            got.vx = m_axis_tdata[20:0];
            got.vy = m_axis_tdata[41:21];
            got.vz = m_axis_tdata[62:42];
            got.last = m_axis_tlast;
            if (vertex_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected vertex %p", got);
            end else begin
                want = vertex_queue.pop_front();
                if (want != got) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("vertex mismatch: expected %p got %p", want, got);
                end
                if (known_first_vx.size() != 0 && got.idx == 2'd0) begin
                    if (known_first_vx.pop_front() != got.vx) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) $display("table vert_x mismatch %p", got);
                    end
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        int phase_pct[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{15, 15}};
        origin_pt = '0; right_pt = '0; down_pt = '0; fwd_dir = '0;
        step_size = sqw_pkg::STEP_RESET;
        plane_depth = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // After reset the plane is all zero: every corner lands at zero.
        rows.push_back('{'{sqw_pkg::OP_AXIS, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0},
                         1, 21'd0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'hA600}, 1, 21'd0});
        foreach (rows[i]) begin
            send_rect(rows[i].req);
            if (rows[i].has_known) known_first_vx.push_back(rows[i].known_vx);
        end
        drain_queue();
        known_first_vx.delete();
        rows.delete();

        write_reg(sqw_pkg::REG_ORIGIN, {21'h100, 21'h200, 21'h300});
        write_reg(sqw_pkg::REG_RIGHT, {21'h100, 21'h200, 21'h28300});
        write_reg(sqw_pkg::REG_DOWN, {21'h100, 21'h1e200, 21'h300});
        write_reg(sqw_pkg::REG_FORWARD, {21'h10000, 21'd0, 21'd0});
        write_reg(sqw_pkg::REG_STEP, 16'hffff);
        rows.push_back('{'{sqw_pkg::OP_BEGIN, 0, 0, 0, 0, 0}, 0, 0});
        rows.push_back('{'{OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
                         0, 0});
        rows.push_back('{'{sqw_pkg::OP_AXIS, 0, 0, 16'd10240, 16'd7680, 0}, 0, 0});
        rows.push_back('{'{sqw_pkg::OP_AXIS, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0},
                         0, 0});
        rows.push_back('{'{sqw_pkg::OP_AXIS, 16'd100, 16'd100, 16'hff00, 16'hff00, 0},
                         0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'd5120, 16'd3840, 16'd1600, 16'd800, 16'd0},
                         0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'd5120, 16'd3840, 16'd1600, 16'd800,
                           16'd5760}, 0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'd5120, 16'd3840, 16'd1600, 16'd800,
                           16'h7fff}, 0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                           16'hA600}, 0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'd11520},
                         0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'd0, 16'd0, 16'd32, 16'd32, 16'd89}, 0, 0});
        rows.push_back('{'{sqw_pkg::OP_ROT, 16'd0, 16'd0, 16'd32, 16'd32, 16'hffd3},
                         0, 0});
        foreach (rows[i]) send_rect(rows[i].req);
        drain_queue();

        // Drive vertices into saturation with wide vectors.
        write_reg(sqw_pkg::REG_FORWARD, {3{21'h0fffff}});
        write_reg(sqw_pkg::REG_ORIGIN, {3{21'h100000}});
        repeat (3) send_rect('{sqw_pkg::OP_AXIS, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0});
        drain_queue();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = phase_pct[ph % 4][0];
            recv_stall_pct = phase_pct[ph % 4][1];
            write_reg(sqw_pkg::REG_ORIGIN, random_vec(ph == 5));
            write_reg(sqw_pkg::REG_RIGHT, random_vec(ph == 5));
            write_reg(sqw_pkg::REG_DOWN, random_vec(ph == 5));
            write_reg(sqw_pkg::REG_FORWARD, random_vec(ph == 6));
            write_reg(sqw_pkg::REG_STEP, ph == 2 ? 16'd0 : 16'($urandom));
            if (ph == 3) hold_off_go = 1'b1;
            for (int n = 0; n < 55; n++) begin
                send_rect(random_rect());
                if (n == 30) drain_queue();
            end
            drain_queue();
        end

        if (mismatch_count == 0 && vertex_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== screen_quad_to_world_vertices.f =====
design/sqw_pkg.sv
design/sqw_queue.sv
design/sqw_front.sv
design/sqw_back.sv
design/screen_quad_to_world_vertices.sv
tb/screen_quad_to_world_vertices_test.sv
